// File: rtl/core/smsd_pkg.sv
// ----------------------------------------------------------------------------
// smsd_pkg: shared types and constants for the sliding median spike detector
// Widths, datapath operation codes and the controller/datapath status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package smsd_pkg;

    localparam int WIN_MAX  = 256;
    localparam int ADDR_W   = $clog2(WIN_MAX);
    localparam int CNT_W    = $clog2(WIN_MAX + 1);
    localparam int SAMPLE_W = 16;
    localparam int TWICE_W  = 17;
    localparam int TOTAL_W  = 32;
    localparam int LEN_W    = 9;
    localparam int OUT_W    = 56;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FILL_START,
        OP_INS_RD,
        OP_INS_WV,
        OP_INS_SHIFT,
        OP_FILL_END,
        OP_MED_HI,
        OP_MED_LO,
        OP_MED_ODD,
        OP_MED_EVEN,
        OP_EVAL,
        OP_OLD_LATCH,
        OP_REM_RD,
        OP_REM_NEXT,
        OP_SHIFT_RD,
        OP_SHIFT_W,
        OP_INS_SETUP,
        OP_FULL_END,
        OP_EMIT
    } op_t;

    typedef struct packed {
        logic pos_zero;
        logic gt;
        logic eq;
        logic pos_lt_len;
        logic pos1_lt_len;
        logic fill_lt_len;
        logic len_odd;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/smsd_ram.sv
// ----------------------------------------------------------------------------
// smsd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/smsd_datapath.sv
// ----------------------------------------------------------------------------
// smsd_datapath: window storage, median and flag arithmetic
// Executes one operation per cycle on the ring, the sorted copy and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire smsd_pkg::op_t                 op,
    output smsd_pkg::status_t                  status,
    input  wire logic                          cfg_we,
    input  wire logic [smsd_pkg::LEN_W-1:0]    cfg_data,
    input  wire logic [smsd_pkg::SAMPLE_W-1:0] in_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [smsd_pkg::OUT_W-1:0]         out_data
);

    logic [smsd_pkg::LEN_W-1:0]    win_len_reg;
    logic [smsd_pkg::CNT_W-1:0]    fill_reg;
    logic [smsd_pkg::ADDR_W-1:0]   oldest_reg;
    logic [smsd_pkg::TOTAL_W-1:0]  flags_reg;
    logic [smsd_pkg::CNT_W-1:0]    pos_reg;
    logic [smsd_pkg::SAMPLE_W-1:0] samp_reg;
    logic [smsd_pkg::SAMPLE_W-1:0] old_reg;
    logic [smsd_pkg::SAMPLE_W-1:0] lo_reg;
    logic [smsd_pkg::TWICE_W-1:0]  twice_reg;
    logic                          chk_reg;
    logic                          ntf_reg;
    logic                          ov_reg;
    logic [smsd_pkg::OUT_W-1:0]    od_reg;

    logic [smsd_pkg::CNT_W-1:0]    len;
    logic [smsd_pkg::CNT_W-1:0]    half;
    logic [smsd_pkg::CNT_W-1:0]    oldest_inc;
    logic [smsd_pkg::CNT_W-1:0]    s_raddr;
    logic [smsd_pkg::SAMPLE_W-1:0] s_rdata;
    logic [smsd_pkg::SAMPLE_W-1:0] r_rdata;
    logic                          s_we;
    logic [smsd_pkg::SAMPLE_W-1:0] s_wdata;
    logic                          r_we;
    logic [smsd_pkg::ADDR_W-1:0]   r_waddr;

    // clamp the length register to 1..WIN_MAX
    always_comb
    begin
        if (win_len_reg == '0)
        begin
            len = smsd_pkg::CNT_W'(1);
        end
        else if (smsd_pkg::CNT_W'(win_len_reg) > smsd_pkg::CNT_W'(smsd_pkg::WIN_MAX))
        begin
            len = smsd_pkg::CNT_W'(smsd_pkg::WIN_MAX);
        end
        else
        begin
            len = smsd_pkg::CNT_W'(win_len_reg);
        end
    end

    assign half       = len >> 1;
    assign oldest_inc = smsd_pkg::CNT_W'(oldest_reg) + smsd_pkg::CNT_W'(1);

    always_comb
    begin
        case (op)
            smsd_pkg::OP_INS_RD:   s_raddr = pos_reg - smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_MED_HI:   s_raddr = half;
            smsd_pkg::OP_MED_LO:   s_raddr = half - smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_SHIFT_RD: s_raddr = pos_reg + smsd_pkg::CNT_W'(1);
            default:               s_raddr = pos_reg;
        endcase
    end

    assign s_we    = (op == smsd_pkg::OP_INS_WV) || (op == smsd_pkg::OP_INS_SHIFT)
                     || (op == smsd_pkg::OP_SHIFT_W);
    assign s_wdata = (op == smsd_pkg::OP_INS_WV) ? samp_reg : s_rdata;
    assign r_we    = (op == smsd_pkg::OP_FILL_START) || (op == smsd_pkg::OP_OLD_LATCH);
    assign r_waddr = (op == smsd_pkg::OP_FILL_START) ? fill_reg[smsd_pkg::ADDR_W-1:0]
                                                     : oldest_reg;

    smsd_ram #(.WIDTH(smsd_pkg::SAMPLE_W), .DEPTH(smsd_pkg::WIN_MAX)) u_sorted (
        .clk   (clk),
        .we    (s_we),
        .waddr (pos_reg[smsd_pkg::ADDR_W-1:0]),
        .wdata (s_wdata),
        .raddr (s_raddr[smsd_pkg::ADDR_W-1:0]),
        .rdata (s_rdata)
    );

    smsd_ram #(.WIDTH(smsd_pkg::SAMPLE_W), .DEPTH(smsd_pkg::WIN_MAX)) u_ring (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (samp_reg),
        .raddr (oldest_reg),
        .rdata (r_rdata)
    );

    assign status.pos_zero    = (pos_reg == '0);
    assign status.gt          = (s_rdata > samp_reg);
    assign status.eq          = (s_rdata == old_reg);
    assign status.pos_lt_len  = (pos_reg < len);
    assign status.pos1_lt_len = ((pos_reg + smsd_pkg::CNT_W'(1)) < len);
    assign status.fill_lt_len = (fill_reg < len);
    assign status.len_odd     = len[0];
    assign status.out_free    = !ov_reg || out_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= smsd_pkg::LEN_W'(5);
            fill_reg    <= '0;
            oldest_reg  <= '0;
            flags_reg   <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                win_len_reg <= cfg_data;
                fill_reg    <= '0;
                oldest_reg  <= '0;
            end
            case (op)
                smsd_pkg::OP_FILL_END:
                begin
                    fill_reg <= fill_reg + smsd_pkg::CNT_W'(1);
                end
                smsd_pkg::OP_EVAL:
                begin
                    if (smsd_pkg::TWICE_W'(samp_reg) >= twice_reg && flags_reg != '1)
                    begin
                        flags_reg <= flags_reg + smsd_pkg::TOTAL_W'(1);
                    end
                    if (smsd_pkg::CNT_W'(oldest_reg) >= len)
                    begin
                        oldest_reg <= '0;
                    end
                end
                smsd_pkg::OP_FULL_END:
                begin
                    oldest_reg <= (oldest_inc >= len) ? '0
                                                      : oldest_inc[smsd_pkg::ADDR_W-1:0];
                end
                default:
                begin
                end
            endcase
            if (op == smsd_pkg::OP_EMIT)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (op)
            smsd_pkg::OP_LOAD:
            begin
                samp_reg  <= in_sample;
                chk_reg   <= 1'b0;
                ntf_reg   <= 1'b0;
                twice_reg <= '0;
            end
            smsd_pkg::OP_FILL_START: pos_reg <= fill_reg;
            smsd_pkg::OP_INS_SHIFT:  pos_reg <= pos_reg - smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_MED_LO:     lo_reg <= s_rdata;
            smsd_pkg::OP_MED_ODD:    twice_reg <= {s_rdata, 1'b0};
            smsd_pkg::OP_MED_EVEN:
            begin
                twice_reg <= smsd_pkg::TWICE_W'(lo_reg) + smsd_pkg::TWICE_W'(s_rdata);
            end
            smsd_pkg::OP_EVAL:
            begin
                chk_reg <= 1'b1;
                ntf_reg <= (smsd_pkg::TWICE_W'(samp_reg) >= twice_reg);
            end
            smsd_pkg::OP_OLD_LATCH:
            begin
                old_reg <= r_rdata;
                pos_reg <= '0;
            end
            smsd_pkg::OP_REM_NEXT:   pos_reg <= pos_reg + smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_SHIFT_W:    pos_reg <= pos_reg + smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_INS_SETUP:  pos_reg <= len - smsd_pkg::CNT_W'(1);
            smsd_pkg::OP_EMIT:
            begin
                od_reg <= {5'b0, flags_reg, twice_reg, ntf_reg, chk_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

`default_nettype wire

// File: rtl/core/smsd_ctrl.sv
// ----------------------------------------------------------------------------
// smsd_ctrl: sequencer for the sliding median spike detector
// Steps the datapath through fill, median, removal and insertion phases.
// ----------------------------------------------------------------------------
`default_nettype none

module smsd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire smsd_pkg::status_t status,
    output smsd_pkg::op_t          op
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_INS,
        S_INS_CMP,
        S_FEND,
        S_MED2,
        S_MED3,
        S_EVAL,
        S_OLD1,
        S_OLD2,
        S_REM,
        S_REM_CMP,
        S_SHIFT,
        S_SHIFT_W,
        S_FULL_END,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   full_reg;
    logic   full_next;
    state_t ins_end;

    assign ins_end  = full_reg ? S_FULL_END : S_FEND;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        full_next  = full_reg;
        op         = smsd_pkg::OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = smsd_pkg::OP_LOAD;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.fill_lt_len)
                begin
                    op         = smsd_pkg::OP_FILL_START;
                    full_next  = 1'b0;
                    state_next = S_INS;
                end
                else
                begin
                    op         = smsd_pkg::OP_MED_HI;
                    full_next  = 1'b1;
                    state_next = S_MED2;
                end
            end
            S_INS:
            begin
                if (status.pos_zero)
                begin
                    op         = smsd_pkg::OP_INS_WV;
                    state_next = ins_end;
                end
                else
                begin
                    op         = smsd_pkg::OP_INS_RD;
                    state_next = S_INS_CMP;
                end
            end
            S_INS_CMP:
            begin
                if (status.gt)
                begin
                    op         = smsd_pkg::OP_INS_SHIFT;
                    state_next = S_INS;
                end
                else
                begin
                    op         = smsd_pkg::OP_INS_WV;
                    state_next = ins_end;
                end
            end
            S_FEND:
            begin
                op         = smsd_pkg::OP_FILL_END;
                state_next = S_EMIT;
            end
            S_MED2:
            begin
                if (status.len_odd)
                begin
                    op         = smsd_pkg::OP_MED_ODD;
                    state_next = S_EVAL;
                end
                else
                begin
                    op         = smsd_pkg::OP_MED_LO;
                    state_next = S_MED3;
                end
            end
            S_MED3:
            begin
                op         = smsd_pkg::OP_MED_EVEN;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                op         = smsd_pkg::OP_EVAL;
                state_next = S_OLD1;
            end
            S_OLD1:
            begin
                state_next = S_OLD2;
            end
            S_OLD2:
            begin
                op         = smsd_pkg::OP_OLD_LATCH;
                state_next = S_REM;
            end
            S_REM:
            begin
                if (status.pos_lt_len)
                begin
                    op         = smsd_pkg::OP_REM_RD;
                    state_next = S_REM_CMP;
                end
                else
                begin
                    op         = smsd_pkg::OP_INS_SETUP;
                    state_next = S_INS;
                end
            end
            S_REM_CMP:
            begin
                if (status.eq)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    op         = smsd_pkg::OP_REM_NEXT;
                    state_next = S_REM;
                end
            end
            S_SHIFT:
            begin
                if (status.pos1_lt_len)
                begin
                    op         = smsd_pkg::OP_SHIFT_RD;
                    state_next = S_SHIFT_W;
                end
                else
                begin
                    op         = smsd_pkg::OP_INS_SETUP;
                    state_next = S_INS;
                end
            end
            S_SHIFT_W:
            begin
                op         = smsd_pkg::OP_SHIFT_W;
                state_next = S_SHIFT;
            end
            S_FULL_END:
            begin
                op         = smsd_pkg::OP_FULL_END;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    op         = smsd_pkg::OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/sliding_median_spike_detector_top.sv
// ----------------------------------------------------------------------------
// sliding_median_spike_detector_top: streaming sliding-window median detector
// Flags samples at or above twice the median of the trailing window once it is full.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one 16-bit unsigned sample and
// produces exactly one result request on the master stream. The last
// window_len samples are kept in a ring RAM and in a sorted RAM; the sorted
// copy is updated by a sequencer that walks it one entry at a time, a read
// state and then a compare or write state per entry, through a single read
// port with registered data. The time a sample takes grows with the entries
// moved by the insertion and, on a full window, with the search position and
// the entries shifted on removal; an odd length skips the second median read,
// and an insertion that stops above the bottom entry adds a last compare.
// The sorted-RAM walk sets this time; a stalled master stream holds the
// sequencer in its emit state. The slave is ready only while the sequencer
// is idle. One result may wait in the output register while the next sample
// is taken in.
// Writing window_len (0 acts as 1, above 256 acts as 256) empties the window
// and keeps the flag total; write it only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_median_spike_detector_top (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration: window_len
    input  wire logic                       cfg_we,
    input  wire logic [smsd_pkg::LEN_W-1:0] cfg_data,
    // slave stream; tdata: sample[15:0]
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [15:0]                s_tdata,
    // master stream; tdata: checked[0], notify[1], median_twice[18:2],
    // notice_total[50:19], zero fill [55:51]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [smsd_pkg::OUT_W-1:0]      m_tdata
);

    smsd_pkg::op_t     op;
    smsd_pkg::status_t status;

    // sequencer: owns the slave handshake, drives one datapath op per cycle
    smsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .op       (op)
    );

    // datapath: RAMs, counters, median arithmetic and the output register
    smsd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_sample (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire
